/* rtl/hsrl_pkg.sv */
// Shared types and codes of the hex stream register loader.
package hsrl_pkg;

  localparam int TICK_BITS = 5;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    CFG_START_ADDRESS = 1'b0,
    CFG_BYTE_COUNT    = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_START_RANGE = 2'd1,
    ST_ZERO_COUNT  = 2'd2,
    ST_OVERRUN     = 2'd3
  } start_status_e;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_ABORT = 2'd1,
    KIND_HEX   = 2'd2,
    KIND_JUNK  = 2'd3
  } item_kind_e;

  typedef struct packed {
    item_kind_e    kind;
    logic [3:0]    nibble;
    start_status_e status;
  } cmd_t;

endpackage

/* rtl/hsrl_if.sv */
// Input and result channel interfaces of the hex stream register loader.
interface hsrl_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_code;

  modport source (output valid, output func, output char_code, input ready);
  modport sink (input valid, input func, input char_code, output ready);
endinterface

interface hsrl_out_if #(
  parameter int AW = 9
);
  localparam int CW = AW + 1;

  logic          valid;
  logic          ready;
  logic          consumed;
  logic [1:0]    start_status;
  logic          write_valid;
  logic [AW-1:0] write_address;
  logic [7:0]    write_data;
  logic          progress_tick;
  logic          load_done;
  logic          load_aborted;
  logic [CW-1:0] bytes_done;

  modport source (
    output valid, output consumed, output start_status, output write_valid,
    output write_address, output write_data, output progress_tick,
    output load_done, output load_aborted, output bytes_done, input ready
  );
  modport sink (
    input valid, input consumed, input start_status, input write_valid,
    input write_address, input write_data, input progress_tick,
    input load_done, input load_aborted, input bytes_done, output ready
  );
endinterface

/* rtl/hex_stream_register_loader.sv */
// Hex stream register loader top level.
// A start transaction (func 0) checks start_address and byte_count and, when the
// check passes, arms the loader; character transactions (func 1) then pair hex
// digits into bytes, each issued as a register write at an incrementing address.
// Every input transaction yields exactly one result transaction. The block takes
// one transaction per cycle while the queue has room: the front end classifies
// it in the accepting cycle, a two-entry command queue decouples it from the
// back end, and the back end pops it, updates the loader state and registers
// the result when its output register is empty or being taken. Output stalls
// back up through the queue; input is accepted while the queue has room.
module hex_stream_register_loader
  import hsrl_pkg::*;
#(
  parameter int ADDRESS_SPACE = 512,
  localparam int AW = $clog2(ADDRESS_SPACE),
  localparam int CW = AW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [CW-1:0] cfg_data_i,
  hsrl_in_if.sink       in_i,
  hsrl_out_if.source    out_o
);

  cmd_t          front_cmd;
  cmd_t          head_cmd;
  logic          queue_full;
  logic          queue_valid;
  logic          pop;
  logic          push;
  logic [AW-1:0] start_address;
  logic [CW-1:0] byte_count;

  assign in_i.ready = !queue_full;
  assign push       = in_i.valid && !queue_full;

  hsrl_front #(
    .ADDRESS_SPACE(ADDRESS_SPACE)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (in_i.func),
    .char_code_i    (in_i.char_code),
    .cmd_o          (front_cmd),
    .start_address_o(start_address),
    .byte_count_o   (byte_count)
  );

  hsrl_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(front_cmd),
    .full_o    (queue_full),
    .pop_i     (pop),
    .valid_o   (queue_valid),
    .head_o    (head_cmd)
  );

  hsrl_back #(
    .ADDRESS_SPACE(ADDRESS_SPACE)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (queue_valid),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .start_address_i(start_address),
    .byte_count_i   (byte_count),
    .out_o          (out_o)
  );

endmodule

/* rtl/hsrl_front.sv */
// Front end: configuration registers, start check and character classification.
module hsrl_front
  import hsrl_pkg::*;
#(
  parameter int ADDRESS_SPACE = 512,
  localparam int AW = $clog2(ADDRESS_SPACE),
  localparam int CW = AW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [CW-1:0] cfg_data_i,
  input  logic          func_i,
  input  logic [7:0]    char_code_i,
  output cmd_t          cmd_o,
  output logic [AW-1:0] start_address_o,
  output logic [CW-1:0] byte_count_o
);

  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [AW-1:0] ADDR_MAX = AW'(ADDRESS_SPACE - 1);
  localparam logic [CW:0] SPACE_W = (CW + 1)'(ADDRESS_SPACE);

  logic [AW-1:0] start_address_q;
  logic [CW-1:0] byte_count_q;
  logic [CW:0]   end_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_address_q <= '0;
      byte_count_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_idx_i))
        CFG_START_ADDRESS: start_address_q <= cfg_data_i[AW-1:0];
        CFG_BYTE_COUNT:    byte_count_q <= cfg_data_i;
      endcase
    end
  end

  assign end_sum = (CW + 1)'(start_address_q) + (CW + 1)'(byte_count_q);

  always_comb begin
    cmd_o.kind   = KIND_JUNK;
    cmd_o.nibble = 4'd0;
    cmd_o.status = ST_OK;
    if (!func_i) begin
      cmd_o.kind = KIND_START;
      priority if (start_address_q > ADDR_MAX) cmd_o.status = ST_START_RANGE;
      else if (byte_count_q == '0) cmd_o.status = ST_ZERO_COUNT;
      else if (end_sum > SPACE_W) cmd_o.status = ST_OVERRUN;
      else cmd_o.status = ST_OK;
    end else begin
      priority if (char_code_i == CHAR_DOT) begin
        cmd_o.kind = KIND_ABORT;
      end else if (char_code_i >= CHAR_0 && char_code_i <= CHAR_9) begin
        cmd_o.kind   = KIND_HEX;
        cmd_o.nibble = char_code_i[3:0];
      end else if ((char_code_i >= CHAR_LA && char_code_i <= CHAR_LF) ||
                   (char_code_i >= CHAR_UA && char_code_i <= CHAR_UF)) begin
        cmd_o.kind   = KIND_HEX;
        cmd_o.nibble = 4'(char_code_i[3:0] + 4'd9);
      end else begin
        cmd_o.kind = KIND_JUNK;
      end
    end
  end

  assign start_address_o = start_address_q;
  assign byte_count_o    = byte_count_q;

endmodule

/* rtl/hsrl_queue.sv */
// Short command queue between the front end and the back end.
module hsrl_queue
  import hsrl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_cmd_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = NW'(count_q + 1'b1);
      2'b01:   count_d = NW'(count_q - 1'b1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign full_o  = (count_q == NW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

endmodule

/* rtl/hsrl_back.sv */
// Back end: loader state, byte assembly and the registered result stage.
module hsrl_back
  import hsrl_pkg::*;
#(
  parameter int ADDRESS_SPACE = 512,
  localparam int AW = $clog2(ADDRESS_SPACE),
  localparam int CW = AW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cmd_t          cmd_i,
  output logic          pop_o,
  input  logic [AW-1:0] start_address_i,
  input  logic [CW-1:0] byte_count_i,
  hsrl_out_if.source    out_o
);

  logic          loading_q, loading_d;
  logic [CW-1:0] next_addr_q, next_addr_d;
  logic [CW-1:0] bytes_left_q, bytes_left_d;
  logic [CW-1:0] bytes_written_q, bytes_written_d;
  logic [3:0]    high_q, high_d;
  logic          held_q, held_d;

  logic          out_valid_q;
  logic          consumed_q, consumed_d;
  logic [1:0]    status_q, status_d;
  logic          wr_valid_q, wr_valid_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic [7:0]    wr_data_q, wr_data_d;
  logic          tick_q, tick_d;
  logic          done_q, done_d;
  logic          abort_q, abort_d;
  logic [CW-1:0] bytes_done_q;

  assign pop_o = cmd_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    loading_d       = loading_q;
    next_addr_d     = next_addr_q;
    bytes_left_d    = bytes_left_q;
    bytes_written_d = bytes_written_q;
    high_d          = high_q;
    held_d          = held_q;
    consumed_d      = 1'b0;
    status_d        = ST_OK;
    wr_valid_d      = 1'b0;
    wr_addr_d       = '0;
    wr_data_d       = '0;
    tick_d          = 1'b0;
    done_d          = 1'b0;
    abort_d         = 1'b0;
    if (cmd_i.kind == KIND_START) begin
      status_d = cmd_i.status;
      if (cmd_i.status == ST_OK) begin
        loading_d       = 1'b1;
        next_addr_d     = CW'(start_address_i);
        bytes_left_d    = byte_count_i;
        bytes_written_d = '0;
        held_d          = 1'b0;
      end
    end else if (loading_q) begin
      consumed_d = 1'b1;
      unique case (cmd_i.kind)
        KIND_ABORT: begin
          loading_d = 1'b0;
          abort_d   = 1'b1;
        end
        KIND_HEX: begin
          if (!held_q) begin
            high_d = cmd_i.nibble;
            held_d = 1'b1;
          end else begin
            held_d          = 1'b0;
            wr_valid_d      = 1'b1;
            wr_addr_d       = next_addr_q[AW-1:0];
            wr_data_d       = {high_q, cmd_i.nibble};
            next_addr_d     = CW'(next_addr_q + 1'b1);
            bytes_written_d = CW'(bytes_written_q + 1'b1);
            bytes_left_d    = CW'(bytes_left_q - 1'b1);
            tick_d          = (bytes_written_d[TICK_BITS-1:0] == '0);
            if (bytes_left_d == '0) begin
              loading_d = 1'b0;
              done_d    = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loading_q       <= 1'b0;
      next_addr_q     <= '0;
      bytes_left_q    <= '0;
      bytes_written_q <= '0;
      high_q          <= '0;
      held_q          <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        loading_q       <= loading_d;
        next_addr_q     <= next_addr_d;
        bytes_left_q    <= bytes_left_d;
        bytes_written_q <= bytes_written_d;
        high_q          <= high_d;
        held_q          <= held_d;
        out_valid_q     <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      consumed_q   <= consumed_d;
      status_q     <= status_d;
      wr_valid_q   <= wr_valid_d;
      wr_addr_q    <= wr_addr_d;
      wr_data_q    <= wr_data_d;
      tick_q       <= tick_d;
      done_q       <= done_d;
      abort_q      <= abort_d;
      bytes_done_q <= bytes_written_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.consumed      = consumed_q;
  assign out_o.start_status  = status_q;
  assign out_o.write_valid   = wr_valid_q;
  assign out_o.write_address = wr_addr_q;
  assign out_o.write_data    = wr_data_q;
  assign out_o.progress_tick = tick_q;
  assign out_o.load_done     = done_q;
  assign out_o.load_aborted  = abort_q;
  assign out_o.bytes_done    = bytes_done_q;

`ifndef ASSERT_OFF
  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && cmd_i.kind == KIND_START && cmd_i.status == ST_OK
    |=> loading_q && !held_q && bytes_written_q == '0)
    else $error("successful start did not arm the loader");

  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && done_d |=> !loading_q && bytes_left_q == '0 && out_o.load_done)
    else $error("last byte did not return the loader to idle");

  a_range_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loading_q |-> bytes_left_q != '0 &&
      ((CW + 1)'(next_addr_q) + (CW + 1)'(bytes_left_q)) <= (CW + 1)'(ADDRESS_SPACE))
    else $error("active load runs past the address space");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the hex stream register loader.
module testbench;
  import hsrl_pkg::*;

  localparam int unsigned ADDR_SPACE = 512;
  localparam int unsigned ITEM_TARGET = 1450;
  localparam int unsigned QUIET_ITEMS = 150;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_CHAR = 1'b1;

  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_DIGIT9 = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_ABORT = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef struct packed {
    logic       consumed;
    logic [1:0] status;
    logic       wr_valid;
    logic [8:0] wr_addr;
    logic [7:0] wr_data;
    logic       tick;
    logic       done;
    logic       aborted;
    logic [9:0] bytes;
  } load_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    cfg_index_e   idx;
    logic [9:0]   data;
    logic         func;
    logic [7:0]   ch;
    logic         typed;
    load_result_t exp;
  } stim_row_t;

  typedef struct {
    bit           typed;
    load_result_t exp;
  } preset_t;

  localparam load_result_t RES_QUIET = '0;
  localparam load_result_t RES_ARMED = '0;
  localparam load_result_t RES_TAKEN =
    '{1'b1, ST_OK, 1'b0, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0, 10'd0};
  localparam load_result_t RES_ZERO_COUNT =
    '{1'b0, ST_ZERO_COUNT, 1'b0, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0, 10'd0};
  localparam load_result_t RES_OVERRUN =
    '{1'b0, ST_OVERRUN, 1'b0, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0, 10'd0};

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [9:0] cfg_data_i;

  hsrl_in_if in_if ();
  hsrl_out_if #(.AW(9)) out_if ();

  hex_stream_register_loader i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  logic [8:0] cfg_start = '0;
  logic [9:0] cfg_count = '0;

  logic       load_active = 1'b0;
  logic [9:0] next_addr = '0;
  logic [9:0] bytes_left = '0;
  logic [9:0] bytes_written = '0;
  logic [3:0] high_nib = '0;
  logic       nib_held = 1'b0;

  load_result_t results_due [$];
  preset_t      preset_q [$];
  stim_row_t    directed_plan [$];

  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          gap_mode = 1'b1;

  wire quiet_tail = (items_taken + QUIET_ITEMS >= ITEM_TARGET);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    if (c >= CH_DIGIT0 && c <= CH_DIGIT9) return {1'b1, c[3:0]};
    if ((c >= CH_UPPER_A && c <= CH_UPPER_F) || (c >= CH_LOWER_A && c <= CH_LOWER_F)) begin
      return {1'b1, c[3:0] + 4'd9};
    end
    return 5'd0;
  endfunction

  function automatic logic [1:0] start_check();
    if (int'(cfg_start) > ADDR_SPACE - 1) return ST_START_RANGE;
    if (cfg_count == '0) return ST_ZERO_COUNT;
    if (int'(cfg_start) + int'(cfg_count) > ADDR_SPACE) return ST_OVERRUN;
    return ST_OK;
  endfunction

  function automatic load_result_t predict_loader(logic f, logic [7:0] c);
    load_result_t r;
    logic [4:0]   d;
    r = '0;
    d = hex_digit(c);
    if (f == FUNC_START) begin
      r.status = start_check();
      if (r.status == ST_OK) begin
        load_active = 1'b1;
        next_addr = {1'b0, cfg_start};
        bytes_left = cfg_count;
        bytes_written = '0;
        nib_held = 1'b0;
      end
    end else if (load_active) begin
      r.consumed = 1'b1;
      if (c == CH_ABORT) begin
        load_active = 1'b0;
        r.aborted = 1'b1;
      end else if (d[4]) begin
        if (!nib_held) begin
          high_nib = d[3:0];
          nib_held = 1'b1;
        end else begin
          nib_held = 1'b0;
          r.wr_valid = 1'b1;
          r.wr_addr = next_addr[8:0];
          r.wr_data = {high_nib, d[3:0]};
          next_addr = next_addr + 10'd1;
          bytes_written = bytes_written + 10'd1;
          bytes_left = bytes_left - 10'd1;
          r.tick = (bytes_written[4:0] == 5'd0);
          if (bytes_left == '0) begin
            load_active = 1'b0;
            r.done = 1'b1;
          end
        end
      end
    end
    r.bytes = bytes_written;
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return CH_DIGIT0 + 8'(v);
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    case ($urandom_range(0, 6))
      0: c = CH_SPACE;
      1: c = CH_TAB;
      2: c = CH_CR;
      3: c = CH_LF;
      4: c = CH_COMMA;
      default: begin
        c = 8'($urandom_range(0, 255));
        while (hex_digit(c) != 5'd0 || c == CH_ABORT) c = 8'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  task automatic check_result(load_result_t want, load_result_t got);
    check_field("consumed", want.consumed, got.consumed);
    check_field("start_status", want.status, got.status);
    check_field("write_valid", want.wr_valid, got.wr_valid);
    check_field("write_address", want.wr_addr, got.wr_addr);
    check_field("write_data", want.wr_data, got.wr_data);
    check_field("progress_tick", want.tick, got.tick);
    check_field("load_done", want.done, got.done);
    check_field("load_aborted", want.aborted, got.aborted);
    check_field("bytes_done", want.bytes, got.bytes);
  endtask

  task automatic send_item(logic f, logic [7:0] c, bit typed = 1'b0,
                           load_result_t typed_exp = '0);
    preset_t p;
    if (!quiet_tail && gap_mode && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    p.typed = typed;
    p.exp = typed_exp;
    preset_q.push_back(p);
    in_if.valid <= 1'b1;
    in_if.func <= f;
    in_if.char_code <= c;
    do @(posedge clk_i); while (!in_if.ready);
    items_taken++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (results_seen != items_taken) @(posedge clk_i);
  endtask

  task automatic set_config(bit wr_start, logic [9:0] start_val, bit wr_count,
                            logic [9:0] count_val);
    if (wr_start) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CFG_START_ADDRESS;
      cfg_data_i <= start_val;
      @(posedge clk_i);
      cfg_start = start_val[8:0];
    end
    if (wr_count) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CFG_BYTE_COUNT;
      cfg_data_i <= count_val;
      @(posedge clk_i);
      cfg_count = count_val;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_load_phase();
    int unsigned count_pick;
    int unsigned start_pick;
    int unsigned n_bytes;
    int unsigned sent;
    int          abort_at;
    int          rearm_at;
    bit          wr_start;
    bit          wr_count;
    bit          armed;
    wait_idle();
    gap_mode = ($urandom_range(0, 2) != 0);
    case ($urandom_range(0, 19))
      0: count_pick = 512;
      1: count_pick = 0;
      2: count_pick = $urandom_range(513, 1023);
      3, 4, 5, 6: count_pick = $urandom_range(41, 130);
      default: count_pick = $urandom_range(1, 40);
    endcase
    if (count_pick == 0 || count_pick > 512 || $urandom_range(0, 7) == 0) begin
      start_pick = $urandom_range(0, 1023);
    end else if ($urandom_range(0, 9) == 0) begin
      start_pick = 512 - count_pick;
    end else begin
      start_pick = $urandom_range(0, 512 - count_pick);
    end
    wr_start = ($urandom_range(0, 4) != 0);
    wr_count = !wr_start || ($urandom_range(0, 4) != 0);
    set_config(wr_start, 10'(start_pick), wr_count, 10'(count_pick));

    armed = (start_check() == ST_OK);
    n_bytes = cfg_count;
    send_item(FUNC_START, 8'($urandom_range(0, 255)));
    if (!armed) begin
      repeat ($urandom_range(1, 4)) send_item(FUNC_CHAR, 8'($urandom_range(0, 255)));
      return;
    end

    abort_at = -1;
    rearm_at = -1;
    if ($urandom_range(0, 9) == 0 || (n_bytes > 130 && $urandom_range(0, 3) != 0)) begin
      abort_at = $urandom_range(0, n_bytes - 1);
    end
    if ($urandom_range(0, 9) == 0) rearm_at = $urandom_range(0, n_bytes - 1);

    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 3) == 0) send_item(FUNC_CHAR, filler_char());
      if (int'(sent) == abort_at) begin
        if ($urandom_range(0, 1)) send_item(FUNC_CHAR, hex_char(4'($urandom)));
        send_item(FUNC_CHAR, CH_ABORT);
        break;
      end
      send_item(FUNC_CHAR, hex_char(4'($urandom)));
      if (int'(sent) == rearm_at) begin
        send_item(FUNC_START, 8'($urandom_range(0, 255)));
        rearm_at = -1;
        sent = 0;
        continue;
      end
      if ($urandom_range(0, 7) == 0) send_item(FUNC_CHAR, filler_char());
      send_item(FUNC_CHAR, hex_char(4'($urandom)));
      sent++;
    end
    repeat ($urandom_range(0, 3)) send_item(FUNC_CHAR, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 120 : 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    load_result_t got;
    load_result_t want;
    preset_t      p;
    bit           moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        results_seen++;
        got = '{out_if.consumed, out_if.start_status, out_if.write_valid,
                out_if.write_address, out_if.write_data, out_if.progress_tick,
                out_if.load_done, out_if.load_aborted, out_if.bytes_done};
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, expected none actual %h", $time, got);
        end else begin
          want = results_due.pop_front();
          check_result(want, got);
        end
      end
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        p = preset_q.pop_front();
        want = predict_loader(in_if.func, in_if.char_code);
        results_due.push_back(p.typed ? p.exp : want);
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    directed_plan = '{
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, "A", 1'b1, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_START, 8'h00, 1'b1, RES_ZERO_COUNT},
      '{ROW_CFG, CFG_START_ADDRESS, 10'd511, FUNC_CHAR, 8'h00, 1'b0, RES_QUIET},
      '{ROW_CFG, CFG_BYTE_COUNT, 10'd2, FUNC_CHAR, 8'h00, 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_START, 8'h00, 1'b1, RES_OVERRUN},
      '{ROW_CFG, CFG_BYTE_COUNT, 10'd1, FUNC_CHAR, 8'h00, 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_START, 8'hFF, 1'b1, RES_ARMED},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, 8'h00, 1'b1, RES_TAKEN},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, "9", 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, "f", 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, "F", 1'b0, RES_QUIET},
      '{ROW_CFG, CFG_START_ADDRESS, 10'h200, FUNC_CHAR, 8'h00, 1'b0, RES_QUIET},
      '{ROW_CFG, CFG_BYTE_COUNT, 10'd512, FUNC_CHAR, 8'h00, 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_START, 8'h00, 1'b1, RES_ARMED},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, "a", 1'b1, RES_TAKEN},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, ",", 1'b1, RES_TAKEN},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, "B", 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, 8'hFF, 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, "0", 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, " ", 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, "0", 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, "F", 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, "f", 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, "7", 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, ".", 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, ".", 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_START, 8'h80, 1'b1, RES_ARMED},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, "E", 1'b1, RES_TAKEN},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_CHAR, ".", 1'b0, RES_QUIET},
      '{ROW_CFG, CFG_BYTE_COUNT, 10'd0, FUNC_CHAR, 8'h00, 1'b0, RES_QUIET},
      '{ROW_ITEM, CFG_START_ADDRESS, 10'd0, FUNC_START, 8'h00, 1'b1, RES_ZERO_COUNT}
    };
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_START_ADDRESS;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.func <= FUNC_START;
    in_if.char_code <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        wait_idle();
        set_config(directed_plan[i].idx == CFG_START_ADDRESS, directed_plan[i].data,
                   directed_plan[i].idx == CFG_BYTE_COUNT, directed_plan[i].data);
      end else begin
        send_item(directed_plan[i].func, directed_plan[i].ch, directed_plan[i].typed,
                  directed_plan[i].exp);
      end
    end

    while (items_taken < ITEM_TARGET) run_load_phase();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (results_due.size() != 0) begin
      mismatches++;
      $display("%0t: results outstanding, expected 0 actual %0d", $time, results_due.size());
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
